@@ rtl/core/mersenne_twister_generator_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the MT19937 generator
// Shared property forms; clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_GENERATOR_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_MACROS_SVH

// same-cycle implication
`define MTG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mtg_pkg.sv @@
// ----------------------------------------------------------------------------
// mtg_pkg
// Constants, types and helper functions of the MT19937 generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam int unsigned TABLE_WORDS = 624;
  localparam int unsigned TWIST_OFFSET = 397;
  localparam int unsigned IDX_W = 10;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_WORDS - 1);
  localparam logic [IDX_W-1:0] FULL_POS = IDX_W'(TABLE_WORDS);
  localparam logic [IDX_W-1:0] UNSEEDED_POS = IDX_W'(TABLE_WORDS + 1);
  localparam logic [IDX_W-1:0] FAR_SPLIT = IDX_W'(TABLE_WORDS - TWIST_OFFSET);
  localparam logic [IDX_W-1:0] FAR_ADD = IDX_W'(TWIST_OFFSET);

  localparam logic [31:0] SEED_MULT = 32'd1812433253;
  localparam logic [31:0] TWIST_XOR = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C = 32'hEFC6_0000;
  localparam logic [30:0] MODULUS_RESET = 31'h7FFF_FFFF;

  localparam logic CMD_SEED = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic        we;
    idx_t        waddr;
    logic [31:0] wdata;
    idx_t        raddr0;
    idx_t        raddr1;
  } mem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

  function automatic logic [31:0] temper(input logic [31:0] v);
    logic [31:0] y;
    y = v;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] twist_mix(input logic [31:0] cur, input logic [31:0] nxt);
    logic [31:0] x;
    logic [31:0] xa;
    x = {cur[31], nxt[30:0]};
    xa = {1'b0, x[31:1]};
    if (x[0]) begin
      xa = xa ^ TWIST_XOR;
    end
    return xa;
  endfunction

endpackage

@@ rtl/core/mtg_table.sv @@
// ----------------------------------------------------------------------------
// mtg_table
// 624 x 32 state memory: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module mtg_table (
  input  logic              clk,
  input  mtg_pkg::mem_req_t req,
  output logic [31:0]       rd0,
  output logic [31:0]       rd1
);

  logic [31:0] mem [mtg_pkg::TABLE_WORDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd0 <= mem[req.raddr0];
    rd1 <= mem[req.raddr1];
  end

endmodule

@@ rtl/core/mtg_remdr.sv @@
// ----------------------------------------------------------------------------
// mtg_remdr
// Radix-2 restoring remainder, one bit per cycle; modulus 0 means 2^31.
// ----------------------------------------------------------------------------
module mtg_remdr (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         dividend,
  input  logic [30:0]         modulus,
  output mtg_pkg::rem_stat_t  stat,
  output logic [30:0]         rem
);

  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] dvd_r;
  logic [30:0] mod_r;
  logic [31:0] trial;
  logic [31:0] step;

  always_comb begin
    trial = {rem_r[30:0], dvd_r[31]};
    if (trial >= {1'b0, mod_r}) begin
      step = trial - {1'b0, mod_r};
    end else begin
      step = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (modulus == '0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= 5'd31;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mod_r <= modulus;
      dvd_r <= dividend;
      if (modulus == '0) begin
        rem_r <= {1'b0, dividend[30:0]};
      end else begin
        rem_r <= '0;
      end
    end else if (busy_r) begin
      rem_r <= step;
      dvd_r <= {dvd_r[30:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem = rem_r[30:0];

endmodule

@@ rtl/core/mersenne_twister_generator.sv @@
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 generator: seed, twist and temper over a 624-word memory, with the
// magnitude of each tempered word reduced modulo a configured limit.
// ----------------------------------------------------------------------------
//   channel  | ports                                   | direction
//   in       | in_valid/in_ready, in_command, in_seed_value | item in
//   out      | out_valid/out_ready, out_random_value, out_not_seeded | item out
//   cfg      | cfg_we, cfg_wdata                       | modulus write
//
// Seed: writes word 0 from the seed, then one multiply and one add per further table word.
// Draw: table read, temper, then the 32-step remainder unit, then the output register.
// A draw that finds the table used up first twists it, with one two-port read
// and one write per word.
// Reset leaves the table unseeded; draws then return 0 with not_seeded set.
// A waiting result sits in the output register while the next item enters.
// ----------------------------------------------------------------------------
`include "mersenne_twister_generator_macros.svh"

module mersenne_twister_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [31:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [30:0] out_random_value,
  output logic        out_not_seeded,
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SEED_MUL = 4'd1;
  localparam logic [3:0] ST_SEED_ADD = 4'd2;
  localparam logic [3:0] ST_TW_PRE   = 4'd3;
  localparam logic [3:0] ST_TW_LOAD  = 4'd4;
  localparam logic [3:0] ST_TW_RD    = 4'd5;
  localparam logic [3:0] ST_TW_WR    = 4'd6;
  localparam logic [3:0] ST_DRAW_RD  = 4'd7;
  localparam logic [3:0] ST_DRAW_TMP = 4'd8;
  localparam logic [3:0] ST_MOD      = 4'd9;
  localparam logic [3:0] ST_OUT      = 4'd10;

  logic [3:0]          state_r;
  logic [3:0]          state_nxt;
  mtg_pkg::idx_t       pos_r;
  mtg_pkg::idx_t       idx_r;
  logic [31:0]         cur_r;
  logic [31:0]         prod_r;
  logic [30:0]         res_r;
  logic                ns_r;
  logic [30:0]         modulus_r;
  logic                out_valid_r;
  logic [30:0]         out_value_r;
  logic                out_ns_r;

  logic                in_acc;
  logic                out_load;
  logic [31:0]         seed_val;
  logic [31:0]         tmp_word;
  logic [31:0]         mag;
  mtg_pkg::idx_t       nxt_idx;
  mtg_pkg::idx_t       far_idx;
  mtg_pkg::mem_req_t   mem_req;
  logic [31:0]         rd0;
  logic [31:0]         rd1;
  logic                rem_start;
  mtg_pkg::rem_stat_t  rem_stat;
  logic [30:0]         rem_val;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  assign seed_val = prod_r + {{(32 - mtg_pkg::IDX_W){1'b0}}, idx_r};
  assign tmp_word = mtg_pkg::temper(rd0);
  assign mag      = tmp_word[31] ? (~tmp_word + 32'd1) : tmp_word;
  assign nxt_idx  = (idx_r == mtg_pkg::LAST_IDX) ? '0 : idx_r + 1'b1;
  assign far_idx  = (idx_r < mtg_pkg::FAR_SPLIT) ? idx_r + mtg_pkg::FAR_ADD
                                                 : idx_r - mtg_pkg::FAR_SPLIT;
  assign rem_start = (state_r == ST_DRAW_TMP);

  always_comb begin
    mem_req        = '0;
    mem_req.raddr0 = pos_r;
    mem_req.raddr1 = far_idx;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_command == mtg_pkg::CMD_SEED)) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = '0;
          mem_req.wdata = in_seed_value;
        end
      end
      ST_SEED_ADD: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = seed_val;
      end
      ST_TW_PRE: begin
        mem_req.raddr0 = '0;
      end
      ST_TW_RD: begin
        mem_req.raddr0 = nxt_idx;
      end
      ST_TW_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = rd1 ^ mtg_pkg::twist_mix(cur_r, rd0);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_command == mtg_pkg::CMD_SEED) begin
            state_nxt = ST_SEED_MUL;
          end else if (pos_r > mtg_pkg::FULL_POS) begin
            state_nxt = ST_OUT;
          end else if (pos_r == mtg_pkg::FULL_POS) begin
            state_nxt = ST_TW_PRE;
          end else begin
            state_nxt = ST_DRAW_RD;
          end
        end
      end
      ST_SEED_MUL: state_nxt = ST_SEED_ADD;
      ST_SEED_ADD: begin
        state_nxt = (idx_r == mtg_pkg::LAST_IDX) ? ST_IDLE : ST_SEED_MUL;
      end
      ST_TW_PRE:  state_nxt = ST_TW_LOAD;
      ST_TW_LOAD: state_nxt = ST_TW_RD;
      ST_TW_RD:   state_nxt = ST_TW_WR;
      ST_TW_WR: begin
        state_nxt = (idx_r == mtg_pkg::LAST_IDX) ? ST_DRAW_RD : ST_TW_RD;
      end
      ST_DRAW_RD:  state_nxt = ST_DRAW_TMP;
      ST_DRAW_TMP: state_nxt = ST_MOD;
      ST_MOD: begin
        if (rem_stat.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= mtg_pkg::UNSEEDED_POS;
      modulus_r   <= mtg_pkg::MODULUS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        modulus_r <= cfg_wdata;
      end
      if ((state_r == ST_SEED_ADD) && (idx_r == mtg_pkg::LAST_IDX)) begin
        pos_r <= mtg_pkg::FULL_POS;
      end else if ((state_r == ST_TW_WR) && (idx_r == mtg_pkg::LAST_IDX)) begin
        pos_r <= '0;
      end else if (state_r == ST_DRAW_TMP) begin
        pos_r <= pos_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        cur_r <= in_seed_value;
        idx_r <= mtg_pkg::idx_t'(1);
        res_r <= '0;
        ns_r  <= 1'b1;
      end
      ST_SEED_MUL: begin
        prod_r <= mtg_pkg::SEED_MULT * (cur_r ^ (cur_r >> 30));
      end
      ST_SEED_ADD: begin
        cur_r <= seed_val;
        idx_r <= idx_r + 1'b1;
      end
      ST_TW_LOAD: begin
        cur_r <= rd0;
        idx_r <= '0;
      end
      ST_TW_WR: begin
        cur_r <= rd0;
        idx_r <= idx_r + 1'b1;
      end
      ST_MOD: begin
        res_r <= rem_val;
        ns_r  <= 1'b0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_value_r <= res_r;
      out_ns_r    <= ns_r;
    end
  end

  mtg_table u_table (
    .clk (clk),
    .req (mem_req),
    .rd0 (rd0),
    .rd1 (rd1)
  );

  mtg_remdr u_remdr (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (mag),
    .modulus  (modulus_r),
    .stat     (rem_stat),
    .rem      (rem_val)
  );

  assign out_valid        = out_valid_r;
  assign out_random_value = out_value_r;
  assign out_not_seeded   = out_ns_r;

  `MTG_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= mtg_pkg::UNSEEDED_POS, "read position out of range")
  `MTG_ASSERT_NOW(a_wr_state, mem_req.we, (state_r == ST_SEED_ADD) || (state_r == ST_TW_WR) || in_acc, "table write outside seed or twist")
  `MTG_ASSERT_NOW(a_rem_done, rem_stat.done, state_r == ST_MOD, "remainder done outside wait state")
  `MTG_ASSERT_NOW(a_ns_zero, out_valid && out_not_seeded, out_random_value == '0, "unseeded item carries a value")
  `MTG_ASSERT_NEXT(a_twist_draw, (state_r == ST_TW_WR) && (idx_r == mtg_pkg::LAST_IDX), (state_r == ST_DRAW_RD) && (pos_r == '0), "twist did not hand over to draw")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression bench for mersenne_twister_generator
// Drives seed and draw items through the valid/ready input channel, predicts
// every draw result with a local MT19937 table, and checks the result channel
// item by item; in phases with idle_on set, both sides stall at random. The modulus register is
// rewritten between phases, including its zero and all-ones settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SETTLE = 1400;
  localparam int unsigned LIMIT = 20000;

  typedef struct {
    logic        cmd;
    logic [31:0] seed;
  } gen_item_t;

  typedef struct {
    logic [30:0] value;
    logic        unseeded;
  } draw_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_command = mtg_pkg::CMD_SEED;
  logic [31:0] in_seed_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [30:0] out_random_value;
  logic        out_not_seeded;
  logic        cfg_we = 1'b0;
  logic [30:0] cfg_wdata = '0;

  gen_item_t    items_to_send[$];
  draw_result_t draws_due[$];

  logic [31:0]   mt_words[mtg_pkg::TABLE_WORDS];
  mtg_pkg::idx_t mt_pos;
  logic [30:0]   modulus_now;

  bit          idle_on;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned quiet_cycles;
  int unsigned errors;

  mersenne_twister_generator DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_seed_value   (in_seed_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_value(out_random_value),
    .out_not_seeded  (out_not_seeded),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] scramble(input logic [31:0] w);
    logic [31:0] y;
    y = w;
    y = y ^ {11'd0, y[31:11]};
    y = y ^ ({y[24:0], 7'd0} & mtg_pkg::TEMPER_B);
    y = y ^ ({y[16:0], 15'd0} & mtg_pkg::TEMPER_C);
    y = y ^ {18'd0, y[31:18]};
    return y;
  endfunction

  task automatic seed_words(input logic [31:0] s);
    logic [31:0] prev;
    mt_words[0] = s;
    for (int i = 1; i < mtg_pkg::TABLE_WORDS; i++) begin
      prev = mt_words[i-1];
      mt_words[i] = mtg_pkg::SEED_MULT * (prev ^ {30'd0, prev[31:30]}) + 32'(i);
    end
    mt_pos = mtg_pkg::FULL_POS;
  endtask

  task automatic twist_words();
    logic [31:0] x;
    logic [31:0] xa;
    for (int i = 0; i < mtg_pkg::TABLE_WORDS; i++) begin
      x = {mt_words[i][31], mt_words[(i + 1) % mtg_pkg::TABLE_WORDS][30:0]};
      xa = {1'b0, x[31:1]};
      if (x[0]) begin
        xa = xa ^ mtg_pkg::TWIST_XOR;
      end
      mt_words[i] = mt_words[(i + mtg_pkg::TWIST_OFFSET) % mtg_pkg::TABLE_WORDS] ^ xa;
    end
    mt_pos = '0;
  endtask

  task automatic predict_item(input logic cmd, input logic [31:0] s);
    logic [31:0] y;
    logic [31:0] mag;
    logic [31:0] rem;
    draw_result_t r;
    if (cmd == mtg_pkg::CMD_SEED) begin
      seed_words(s);
    end else if (mt_pos > mtg_pkg::FULL_POS) begin
      r.value = '0;
      r.unseeded = 1'b1;
      draws_due.push_back(r);
    end else begin
      if (mt_pos == mtg_pkg::FULL_POS) begin
        twist_words();
      end
      y = scramble(mt_words[mt_pos]);
      mt_pos = mt_pos + 1'b1;
      mag = y[31] ? (32'd0 - y) : y;
      if (modulus_now == '0) begin
        rem = mag;
      end else begin
        rem = mag % {1'b0, modulus_now};
      end
      r.value = rem[30:0];
      r.unseeded = 1'b0;
      draws_due.push_back(r);
    end
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(20, 150);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("mismatch on %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // input driver
  always @(posedge clk) begin : drive_in
    logic      fire;
    gen_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        predict_item(in_command, in_seed_value);
        send_gap = idle_on ? pick_gap() : 0;
      end
      if (fire || !in_valid) begin
        if (send_gap == 0 && items_to_send.size() != 0) begin
          nxt = items_to_send.pop_front();
          in_valid <= 1'b1;
          in_command <= nxt.cmd;
          in_seed_value <= nxt.seed;
        end else begin
          in_valid <= 1'b0;
          if (send_gap != 0) begin
            send_gap--;
          end
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_out
    draw_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (draws_due.size() == 0) begin
          flag_mismatch("unexpected item", {1'b0, out_random_value}, 32'd0);
        end else begin
          want = draws_due.pop_front();
          if (out_random_value !== want.value) begin
            flag_mismatch("random_value", {1'b0, out_random_value}, {1'b0, want.value});
          end
          if (out_not_seeded !== want.unseeded) begin
            flag_mismatch("not_seeded", {31'd0, out_not_seeded}, {31'd0, want.unseeded});
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        out_ready <= (stall_left == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == LIMIT) begin
      $display("mersenne_twister_generator regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_item(input logic cmd, input logic [31:0] s);
    gen_item_t it;
    it.cmd = cmd;
    it.seed = s;
    items_to_send.push_back(it);
  endtask

  task automatic wait_drained();
    while (items_to_send.size() != 0 || in_valid || draws_due.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // seeds may still be filling the table with nothing expected, so hold off
  task automatic set_modulus(input logic [30:0] m);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    modulus_now = m;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_seed();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return 32'd0;
    end else if (r == 1) begin
      return 32'hFFFF_FFFF;
    end
    return $urandom;
  endfunction

  task automatic add_random(input int n, input int seed_pct, input bit lead_seed);
    if (lead_seed) begin
      push_item(mtg_pkg::CMD_SEED, pick_seed());
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < seed_pct) begin
        push_item(mtg_pkg::CMD_SEED, pick_seed());
      end else begin
        push_item(mtg_pkg::CMD_DRAW, $urandom);
      end
    end
  endtask

  initial begin
    modulus_now = mtg_pkg::MODULUS_RESET;
    mt_pos = mtg_pkg::UNSEEDED_POS;
    idle_on = 1'b1;
    errors = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: draws before seed, extreme seeds, modulus extremes
    set_modulus(31'h7FFF_FFFF);
    push_item(mtg_pkg::CMD_DRAW, 32'hFFFF_FFFF);
    push_item(mtg_pkg::CMD_DRAW, 32'd0);
    push_item(mtg_pkg::CMD_SEED, 32'd0);
    repeat (3) push_item(mtg_pkg::CMD_DRAW, $urandom);
    push_item(mtg_pkg::CMD_SEED, 32'hFFFF_FFFF);
    repeat (2) push_item(mtg_pkg::CMD_DRAW, $urandom);
    push_item(mtg_pkg::CMD_SEED, 32'd5489);
    repeat (3) push_item(mtg_pkg::CMD_DRAW, $urandom);
    set_modulus(31'd0);
    push_item(mtg_pkg::CMD_SEED, $urandom);
    repeat (3) push_item(mtg_pkg::CMD_DRAW, $urandom);
    set_modulus(31'd1);
    repeat (2) push_item(mtg_pkg::CMD_DRAW, $urandom);
    set_modulus(31'd2);
    repeat (3) push_item(mtg_pkg::CMD_DRAW, $urandom);
    push_item(mtg_pkg::CMD_SEED, 32'h8000_0000);
    push_item(mtg_pkg::CMD_DRAW, $urandom);

    // random phases
    set_modulus(31'($urandom_range(1, 32'h7FFF_FFFF)));
    add_random(200, 3, 1'b0);
    set_modulus(31'($urandom_range(1, 16)));
    idle_on = 1'b0;
    add_random(150, 4, 1'b1);
    set_modulus(31'h7FFF_FFFF);
    idle_on = 1'b1;
    // long unbroken run so the table wears out and twists on its own
    add_random(700, 0, 1'b1);
    set_modulus(31'd0);
    add_random(150, 5, 1'b1);
    set_modulus(31'd1);
    idle_on = 1'b0;
    add_random(50, 4, 1'b0);
    set_modulus(31'($urandom_range(32'h4000_0000, 32'h7FFF_FFFE)));
    idle_on = 1'b1;
    add_random(150, 3, 1'b1);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("mersenne_twister_generator regression: pass");
    end else begin
      $display("mersenne_twister_generator regression: fail");
    end
    $finish;
  end

endmodule
